>>> design/pbat_pkg.sv
// Package for the aging blacklist table: transfer payload types, entry layout
// and command codes. It depends on nothing else.
package pbat_pkg;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pan_id;
        logic [15:0] amount;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic       dropped;
        logic [4:0] entries_in_use;
    } t_out_item;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] remain_s;
    } t_entry;

    localparam int unsigned COUNT_MAX = 31;

endpackage

>>> design/pbat_entry_mem.sv
// Entry memory of the aging blacklist table: key and remaining seconds per slot.
// One write port and one read port with registered read data; uses pbat_pkg.
module pbat_entry_mem #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output pbat_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  pbat_pkg::t_entry  i_wr_data
);

    pbat_pkg::t_entry r_mem [ENTRIES];
    pbat_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/pan_id_blacklist_aging_table.sv
// Top level of the aging blacklist table of 16-bit network identifiers.
// Uses pbat_pkg and pbat_entry_mem.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_item carries one command per
//   transfer: set or refresh a key with a timeout, age all entries by the
//   elapsed seconds, or query a key. Output channel o_out_valid / i_out_stall /
//   o_out_item returns exactly one result per command, in command order.
//   Every set, tick or query command walks all ENTRIES slots of the entry
//   memory through its single read port, one slot per cycle, comparing the
//   slot read in the previous cycle. A tick writes aged entries back behind
//   the read pointer. A command goes through the scan, write and done states,
//   and its result is registered in the done state. The unused command code
//   skips the scan and write states and goes straight to the done state. One
//   command is in work at a time.
//   The output register holds a finished result while the receiver stalls;
//   the next command is still accepted meanwhile, and its result waits in the
//   sequencer until the output register is free.
//   Reset clears all valid bits and the entry count at once; key and time
//   storage keeps its contents and is read only behind a valid bit.
module pan_id_blacklist_aging_table #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbat_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbat_pkg::t_out_item o_out_item
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic [1:0]          r_cmd;
    logic [15:0]         r_key;
    logic [15:0]         r_amount;
    logic                r_match;
    logic [IW-1:0]       r_match_idx;
    logic                r_free;
    logic [IW-1:0]       r_free_idx;
    logic [ENTRIES-1:0]  r_valid;
    logic [CW-1:0]       r_count;
    logic                r_out_vld;
    pbat_pkg::t_out_item r_out;

    logic                mem_rd_en;
    pbat_pkg::t_entry    mem_rd_data;
    logic                mem_wr_en;
    logic [IW-1:0]       mem_wr_addr;
    pbat_pkg::t_entry    mem_wr_data;
    logic                cmp_slot_vld;
    logic                tick_keep;
    logic                tick_free;
    logic                set_store;
    logic [IW-1:0]       set_slot;
    logic [31:0]         count_ext;
    logic [4:0]          count_sat;

    assign mem_rd_en    = (r_state == S_SCAN) && (r_idx < CW'(ENTRIES));
    assign cmp_slot_vld = r_cmp_vld && r_valid[r_cmp_idx];
    assign tick_keep    = (r_state == S_SCAN) && (r_cmd == pbat_pkg::CMD_TICK)
                          && cmp_slot_vld && (mem_rd_data.remain_s > r_amount);
    assign tick_free    = (r_state == S_SCAN) && (r_cmd == pbat_pkg::CMD_TICK)
                          && cmp_slot_vld && !(mem_rd_data.remain_s > r_amount);
    assign set_store    = (r_state == S_WRITE) && (r_cmd == pbat_pkg::CMD_SET)
                          && (r_match || r_free);
    assign set_slot     = r_match ? r_match_idx : r_free_idx;

    always_comb begin
        mem_wr_en   = tick_keep || set_store;
        mem_wr_addr = set_store ? set_slot : r_cmp_idx;
        if (set_store) begin
            mem_wr_data.key      = r_key;
            mem_wr_data.remain_s = r_amount;
        end else begin
            mem_wr_data.key      = mem_rd_data.key;
            mem_wr_data.remain_s = mem_rd_data.remain_s - r_amount;
        end
    end

    assign count_ext = 32'(r_count);
    assign count_sat = (count_ext > pbat_pkg::COUNT_MAX) ? 5'(pbat_pkg::COUNT_MAX)
                                                         : count_ext[4:0];

    pbat_entry_mem #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_in_item.cmd;
                        r_key     <= i_in_item.pan_id;
                        r_amount  <= i_in_item.amount;
                        r_match   <= 1'b0;
                        r_free    <= 1'b0;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= (i_in_item.cmd == pbat_pkg::CMD_NONE) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx < CW'(ENTRIES)) begin
                        r_cmp_idx <= r_idx[IW-1:0];
                        r_cmp_vld <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                        if (!r_cmp_vld) begin
                            r_state <= S_WRITE;
                        end
                    end
                    if (r_cmp_vld && (r_cmd != pbat_pkg::CMD_TICK)) begin
                        if (cmp_slot_vld && (mem_rd_data.key == r_key) && !r_match) begin
                            r_match     <= 1'b1;
                            r_match_idx <= r_cmp_idx;
                        end
                        if (!r_valid[r_cmp_idx] && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                    end
                    if (tick_free) begin
                        r_valid[r_cmp_idx] <= 1'b0;
                        r_count            <= r_count - 1'b1;
                    end
                end
                S_WRITE: begin
                    if (set_store) begin
                        r_valid[set_slot] <= 1'b1;
                        if (!r_match) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld            <= 1'b1;
                        r_out.hit            <= (r_cmd == pbat_pkg::CMD_QUERY) && r_match;
                        r_out.dropped        <= (r_cmd == pbat_pkg::CMD_SET)
                                                && !r_match && !r_free;
                        r_out.entries_in_use <= count_sat;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

>>> design/pbat_checker.sv
// Port-level checker for the aging blacklist table and its bind statement.
// Uses pbat_pkg; attaches to pan_id_blacklist_aging_table.
module pbat_checker #(
    parameter int ENTRIES = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pbat_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pbat_pkg::t_out_item o_out_item
);

    localparam int SAT = (ENTRIES > 31) ? 31 : ENTRIES;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("Stalled result transfer changed or vanished.");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A second command was taken while one was in work.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.entries_in_use) <= SAT))
        else $error("Entry count exceeds the table size.");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.dropped) |->
        (32'(o_out_item.entries_in_use) == SAT && !o_out_item.hit))
        else $error("Set was dropped while the table was not full.");

endmodule

bind pan_id_blacklist_aging_table pbat_checker #(.ENTRIES(ENTRIES)) u_pbat_checker (.*);
